// ----- hdl/apfs_pkg.sv -----
// ----------------------------------------------------------------------------
// APA102 panel frame streamer package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package apfs_pkg;

    localparam int PANEL_WIDTH = 24;
    localparam int PIXEL_COUNT = 576;
    localparam int START_BYTES = 8;
    localparam int END_BYTES   = 32;

    localparam int FRAME_TOTAL = START_BYTES + 4 * PIXEL_COUNT + END_BYTES;
    localparam int IDX_W       = $clog2(PIXEL_COUNT);
    localparam int POS_W       = $clog2(FRAME_TOTAL);
    localparam int MAP_W       = 9 + $clog2(PANEL_WIDTH);
    localparam int TAG_W       = 8;
    localparam int MISS_W      = 10;
    localparam int CFG_ADDR_W  = 2;
    localparam int IN_DATA_W   = 88;

    localparam logic [7:0] BRIGHT_MARK = 8'hE0;
    localparam logic [7:0] OFF_BRIGHT  = 8'hF0;
    localparam logic [7:0] END_FILL    = 8'hFF;
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = '1;

    typedef enum logic [2:0] {
        CMD_SET_RGB = 3'd0,
        CMD_SET_RAW = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_START   = 3'd3,
        CMD_NEXT    = 3'd4
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MISSING_COUNT = 2'd0,
        REG_MISSING_A     = 2'd1,
        REG_MISSING_B     = 2'd2
    } reg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic map_index;
        logic write_pixel;
        logic epoch_inc;
        logic sweep_start;
        logic sweep_step;
        logic frame_start;
        logic rd_issue;
        logic emit;
    } apfs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t command;
        logic frame_enable;
        logic frame_active;
        logic epoch_last;
        logic sweep_done;
        logic out_free;
    } apfs_stat_t;

endpackage

// ----- hdl/apfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// APA102 panel frame streamer controller
// Sequences request decode, pixel writes, frame byte fetch and store sweeps.
// ----------------------------------------------------------------------------
module apfs_ctrl
    import apfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  apfs_stat_t stat,
    output apfs_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_MAP    = 7'b0000100,
        ST_WRITE  = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_SWEEP  = 7'b0100000,
        ST_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                case (stat.command)
                    CMD_SET_RGB, CMD_SET_RAW: begin
                        cmd.map_index = 1'b1;
                        state_next    = ST_MAP;
                    end
                    CMD_CLEAR: begin
                        // tag space exhausted: wipe every tag before reuse
                        if (stat.epoch_last) begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_SWEEP;
                        end else begin
                            cmd.epoch_inc = 1'b1;
                        end
                    end
                    CMD_START: begin
                        cmd.frame_start = stat.frame_enable;
                    end
                    CMD_NEXT: begin
                        if (stat.frame_active) begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_FETCH;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MAP: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write_pixel = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FETCH: begin
                // hold until the output register can take the byte
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/apfs_datapath.sv -----
// ----------------------------------------------------------------------------
// APA102 panel frame streamer datapath
// Request capture, index mapping, tagged pixel store, frame byte output.
// ----------------------------------------------------------------------------
module apfs_datapath
    import apfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [MISS_W-1:0]     cfg_wr_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  apfs_cmd_t             cmd,
    output apfs_stat_t            stat
);

    localparam int ENTRY_W = TAG_W + 32;

    // configuration
    logic [1:0]        miss_cnt_reg;
    logic [MISS_W-1:0] miss_a_reg;
    logic [MISS_W-1:0] miss_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_cnt_reg <= '0;
            miss_a_reg   <= '0;
            miss_b_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_MISSING_COUNT: miss_cnt_reg <= cfg_wr_data[1:0];
                REG_MISSING_A:     miss_a_reg   <= cfg_wr_data;
                REG_MISSING_B:     miss_b_reg   <= cfg_wr_data;
                default:           miss_cnt_reg <= miss_cnt_reg;
            endcase
        end
    end

    // captured request
    cmd_t        cmd_reg;
    logic [7:0]  x_reg;
    logic [7:0]  y_reg;
    logic [7:0]  bright_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [31:0] raw_reg;
    logic        enable_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= cmd_t'(s_tuser);
            x_reg      <= s_tdata[7:0];
            y_reg      <= s_tdata[15:8];
            bright_reg <= s_tdata[23:16];
            red_reg    <= s_tdata[31:24];
            green_reg  <= s_tdata[39:32];
            blue_reg   <= s_tdata[47:40];
            raw_reg    <= s_tdata[79:48];
            enable_reg <= s_tdata[80];
        end
    end

    // index mapping: the multiply is registered, the missing LED skip is combinational
    logic [MAP_W-1:0] map_raw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.map_index) begin
            map_raw_reg <= MAP_W'(y_reg) * MAP_W'(PANEL_WIDTH) + MAP_W'(x_reg);
        end
    end

    logic [IDX_W-1:0] idx_base;
    logic [IDX_W-1:0] idx_adj1;
    logic [IDX_W-1:0] idx_adj2;
    logic [31:0]      pixel_word;

    always_comb begin
        idx_base = (map_raw_reg >= MAP_W'(PIXEL_COUNT)) ? '0 : map_raw_reg[IDX_W-1:0];
        idx_adj1 = idx_base;
        if ((miss_cnt_reg != 2'd0) && (16'(idx_base) >= 16'(miss_a_reg))
                && (idx_adj1 != '0)) begin
            idx_adj1 = idx_base - IDX_W'(1);
        end
        idx_adj2 = idx_adj1;
        // a count of three acts as two
        if (miss_cnt_reg[1] && (16'(idx_base) >= 16'(miss_b_reg))
                && (idx_adj1 != '0)) begin
            idx_adj2 = idx_adj1 - IDX_W'(1);
        end
        if (cmd_reg == CMD_SET_RGB) begin
            pixel_word = {bright_reg | BRIGHT_MARK, red_reg, green_reg, blue_reg};
        end else begin
            pixel_word = raw_reg;
        end
    end

    // clear tag and sweep counter
    logic [TAG_W-1:0] epoch_reg;
    logic [IDX_W-1:0] sweep_cnt_reg;
    logic             sweep_done;

    assign sweep_done = (sweep_cnt_reg == IDX_W'(PIXEL_COUNT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg     <= TAG_FIRST;
            sweep_cnt_reg <= '0;
        end else begin
            if (cmd.epoch_inc) begin
                epoch_reg <= epoch_reg + TAG_W'(1);
            end else if (cmd.sweep_step && sweep_done) begin
                epoch_reg <= TAG_FIRST;
            end
            if (cmd.sweep_start) begin
                sweep_cnt_reg <= '0;
            end else if (cmd.sweep_step && !sweep_done) begin
                sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
            end
        end
    end

    // pixel store: tag plus word, an entry counts only if its tag is current
    logic [ENTRY_W-1:0] pixel_mem [PIXEL_COUNT];
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    assign mem_wr_en   = cmd.write_pixel || cmd.sweep_step;
    assign mem_wr_addr = cmd.sweep_step ? sweep_cnt_reg : idx_adj2;
    assign mem_wr_data = cmd.sweep_step ? '0 : {epoch_reg, pixel_word};

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            pixel_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // frame position
    logic             frame_active_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] rel;
    logic             in_start;
    logic             in_pixels;
    logic             pos_last;

    assign rel       = pos_reg - POS_W'(START_BYTES);
    assign in_start  = (pos_reg < POS_W'(START_BYTES));
    assign in_pixels = !in_start && (rel < POS_W'(4 * PIXEL_COUNT));
    assign pos_last  = (pos_reg == POS_W'(FRAME_TOTAL - 1));

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue && in_pixels) begin
            rd_entry_reg <= pixel_mem[rel[IDX_W+1:2]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_active_reg <= 1'b0;
            pos_reg          <= '0;
        end else if (cmd.frame_start) begin
            frame_active_reg <= 1'b1;
            pos_reg          <= '0;
        end else if (cmd.emit) begin
            frame_active_reg <= !pos_last;
            pos_reg          <= pos_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    // frame byte select
    logic [31:0] word;
    logic [7:0]  frame_byte;

    always_comb begin
        word = (rd_entry_reg[ENTRY_W-1:32] == epoch_reg) ? rd_entry_reg[31:0] : '0;
        if (in_start) begin
            frame_byte = 8'h00;
        end else if (!in_pixels) begin
            frame_byte = END_FILL;
        end else if (word == '0) begin
            frame_byte = (rel[1:0] == 2'd0) ? OFF_BRIGHT : 8'h00;
        end else begin
            case (rel[1:0])
                2'd0:    frame_byte = word[31:24];
                2'd1:    frame_byte = word[7:0];
                2'd2:    frame_byte = word[15:8];
                default: frame_byte = word[23:16];
            endcase
        end
    end

    // output register
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_first_reg;
    logic       m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg  <= frame_byte;
            m_first_reg <= (pos_reg == '0);
            m_last_reg  <= pos_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_first_reg;
    assign m_tlast  = m_last_reg;

    assign stat.command      = cmd_reg;
    assign stat.frame_enable = enable_reg;
    assign stat.frame_active = frame_active_reg;
    assign stat.epoch_last   = (epoch_reg == TAG_LAST);
    assign stat.sweep_done   = sweep_done;
    assign stat.out_free     = !m_valid_reg || m_tready;

endmodule

// ----- hdl/apa102_panel_frame_streamer.sv -----
// ----------------------------------------------------------------------------
// APA102 panel frame streamer
// Pixel frame buffer for a 24x24 APA102 panel and its serial byte stream.
//
//   channel  direction  ports                      content
//   s_       in         tvalid tready tdata tuser  one command request
//   m_       out        tvalid tready tdata tuser  one frame byte, tlast
//   cfg_     in         wr_en addr wr_data         missing LED registers
//
// A next byte request steps through accept, store read and byte select, and
// waits there while the output register is full; set pixel steps through
// accept, decode, multiply, and skip and write; clear and start take accept
// and decode. Every 255th clear, and reset, run a sweep of all 576 store tags
// during which s_tready stays low; configuration writes are still taken.
// A stalled output holds the byte register; a following request is taken.
// ----------------------------------------------------------------------------
module apa102_panel_frame_streamer
    import apfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // x[7:0] y[15:8] brightness[23:16] red[31:24] green[39:32] blue[47:40]
    // raw_colour[79:48] frame_enable[80], zero above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // data_byte[7:0]
    output logic [7:0]            m_tdata,
    // first_of_frame[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [MISS_W-1:0]     cfg_wr_data
);

    apfs_cmd_t  cmd;
    apfs_stat_t stat;

    apfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apfs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ----- tb/apa102_panel_frame_streamer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// APA102 panel frame streamer testbench
// Drives command requests with random gaps and output stalls, keeps its own
// copy of the pixel store, valid bits and frame position, and checks every
// frame byte with its first and last flags against that copy. Covers short
// and restarted frames, a long clear burst past the tag wrap, and several
// missing LED settings including the extremes.
// ----------------------------------------------------------------------------
module apa102_panel_frame_streamer_tb;
    import apfs_pkg::*;

    localparam int         STALL_LIMIT      = 3000;
    localparam logic [2:0] CMD_RESERVED_MIN = 3'd5;
    localparam logic [2:0] CMD_RESERVED_MAX = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  x, y, bright, red, green, blue;
        logic [31:0] raw;
        logic        en;
    } panel_req_t;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } frame_byte_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [2:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [MISS_W-1:0]     cfg_wr_data = '0;

    apa102_panel_frame_streamer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    panel_req_t  pending[$];
    panel_req_t  cur_req;
    frame_byte_t byte_expect[$];
    bit          req_taken;
    int          idle_pct     = 32;
    int          mismatches   = 0;
    int          stall_cycles = 0;

    // panel state as the block should hold it
    logic [31:0]       led_word [PIXEL_COUNT];
    bit                led_live [PIXEL_COUNT];
    bit                frm_on   = 1'b0;
    int unsigned       frm_pos  = 0;
    logic [1:0]        miss_cnt = '0;
    logic [MISS_W-1:0] miss_a   = '0;
    logic [MISS_W-1:0] miss_b   = '0;

    task automatic panel_model_apply(input panel_req_t r);
        int unsigned led, spot, rel;
        logic [31:0] word;
        frame_byte_t fb;
        case (r.cmd)
            CMD_SET_RGB, CMD_SET_RAW: begin
                spot = r.y * PANEL_WIDTH + r.x;
                if (spot >= PIXEL_COUNT) spot = 0;
                led = spot;
                // count three behaves as two; never step below LED 0
                if (miss_cnt >= 1 && spot >= miss_a && led > 0) led--;
                if (miss_cnt >= 2 && spot >= miss_b && led > 0) led--;
                led_word[led] = (r.cmd == CMD_SET_RGB) ?
                    {r.bright | BRIGHT_MARK, r.red, r.green, r.blue} : r.raw;
                led_live[led] = 1'b1;
            end
            CMD_CLEAR: begin
                foreach (led_live[i]) led_live[i] = 1'b0;
            end
            CMD_START: begin
                if (r.en) begin
                    frm_on  = 1'b1;
                    frm_pos = 0;
                end
            end
            CMD_NEXT: begin
                if (frm_on) begin
                    if (frm_pos < START_BYTES) begin
                        fb.data = 8'h00;
                    end else if (frm_pos >= START_BYTES + 4 * PIXEL_COUNT) begin
                        fb.data = END_FILL;
                    end else begin
                        rel  = frm_pos - START_BYTES;
                        word = led_live[rel / 4] ? led_word[rel / 4] : 32'h0;
                        if (word == 32'h0) begin
                            fb.data = (rel % 4 == 0) ? OFF_BRIGHT : 8'h00;
                        end else begin
                            // wire order: brightness, blue, green, red
                            case (rel % 4)
                                0: fb.data = word[31:24];
                                1: fb.data = word[7:0];
                                2: fb.data = word[15:8];
                                default: fb.data = word[23:16];
                            endcase
                        end
                    end
                    fb.first = (frm_pos == 0);
                    fb.last  = (frm_pos + 1 >= FRAME_TOTAL);
                    byte_expect.push_back(fb);
                    if (fb.last) begin
                        frm_on  = 1'b0;
                        frm_pos = 0;
                    end else begin
                        frm_pos++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // request source: holds a request until taken, inserts random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || req_taken) begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {7'd0, cur_req.en, cur_req.raw, cur_req.blue,
                                 cur_req.green, cur_req.red, cur_req.bright,
                                 cur_req.y, cur_req.x};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // check the oldest expectation first, then predict the request taken here
    always @(posedge aclk) begin
        frame_byte_t want;
        if (m_tvalid && m_tready) begin
            if (byte_expect.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual data %h first %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = byte_expect.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: data_byte mismatch: expected %h, actual %h",
                             $time, want.data, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.first) begin
                    $display("%0t: first_of_frame mismatch: expected %b, actual %b",
                             $time, want.first, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_of_frame mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MISSING_COUNT: miss_cnt = cfg_wr_data[1:0];
                REG_MISSING_A:     miss_a   = cfg_wr_data;
                REG_MISSING_B:     miss_b   = cfg_wr_data;
                default: ;
            endcase
        end
        req_taken = s_tvalid && s_tready;
        if (req_taken) panel_model_apply(cur_req);
        if (req_taken || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL apa102_panel_frame_streamer");
            $finish;
        end
    end

    function automatic panel_req_t rand_req(input logic [2:0] cmd);
        panel_req_t  r;
        int unsigned pick;
        r.cmd    = cmd;
        r.x      = 8'($urandom);
        r.y      = 8'($urandom);
        r.bright = 8'($urandom);
        r.red    = 8'($urandom);
        r.green  = 8'($urandom);
        r.blue   = 8'($urandom);
        r.raw    = $urandom;
        r.en     = 1'($urandom);
        pick = $urandom_range(99);
        // favour the first LEDs, which short frames actually reach
        if (pick < 45) begin
            r.y = 8'd0;
            r.x = 8'($urandom_range(15));
        end else if (pick < 80) begin
            r.x = 8'($urandom_range(PANEL_WIDTH - 1));
            r.y = 8'($urandom_range(PANEL_WIDTH - 1));
        end
        if ($urandom_range(9) == 0) r.raw = 32'h0;
        return r;
    endfunction

    function automatic panel_req_t start_req(input logic en);
        panel_req_t r;
        r    = rand_req(CMD_START);
        r.en = en;
        return r;
    endfunction

    function automatic panel_req_t pixel_req(input logic [2:0] cmd, input logic [7:0] x,
                                             input logic [7:0] y, input logic [31:0] word);
        panel_req_t r;
        r        = rand_req(cmd);
        r.x      = x;
        r.y      = y;
        r.bright = word[31:24];
        r.red    = word[23:16];
        r.green  = word[15:8];
        r.blue   = word[7:0];
        r.raw    = word;
        return r;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [MISS_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_missing(input logic [1:0] cnt, input logic [MISS_W-1:0] a,
                               input logic [MISS_W-1:0] b);
        write_reg(REG_MISSING_COUNT, MISS_W'(cnt));
        write_reg(REG_MISSING_A, a);
        write_reg(REG_MISSING_B, b);
    endtask

    // wait for every request and byte, then let the set pipeline empty
    task automatic settle();
        while (pending.size() != 0 || s_tvalid || byte_expect.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic queue_mixed(input int n);
        int unsigned pick;
        pending.push_back(start_req(1'b1));
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 63)      pending.push_back(rand_req(CMD_NEXT));
            else if (pick < 76) pending.push_back(rand_req(CMD_SET_RGB));
            else if (pick < 88) pending.push_back(rand_req(CMD_SET_RAW));
            else if (pick < 90) pending.push_back(start_req(1'b1));
            else if (pick < 93) pending.push_back(start_req(1'b0));
            else if (pick < 95) pending.push_back(rand_req(CMD_CLEAR));
            else if (pick < 98)
                pending.push_back(rand_req(3'($urandom_range(CMD_RESERVED_MAX,
                                                             CMD_RESERVED_MIN))));
            else                pending.push_back(rand_req(CMD_NEXT));
        end
    endtask

    // enough clears to wrap the store tags and force a sweep
    task automatic queue_clear_burst();
        repeat (16) pending.push_back(rand_req(CMD_SET_RGB));
        repeat (300) begin
            pending.push_back(rand_req(CMD_CLEAR));
            if ($urandom_range(4) == 0) pending.push_back(rand_req(CMD_SET_RAW));
        end
        pending.push_back(start_req(1'b1));
        repeat (80) pending.push_back(rand_req(CMD_NEXT));
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        pending.push_back(rand_req(CMD_NEXT));
        pending.push_back(start_req(1'b0));
        pending.push_back(rand_req(CMD_RESERVED_MAX));
        // zero brightness and colour still carries the brightness mark
        pending.push_back(pixel_req(CMD_SET_RGB, 8'd0, 8'd0, 32'h0000_0000));
        pending.push_back(pixel_req(CMD_SET_RAW, 8'd1, 8'd0, 32'hFFFF_FFFF));
        pending.push_back(pixel_req(CMD_SET_RGB, 8'd255, 8'd255, 32'h1F11_2233));
        pending.push_back(pixel_req(CMD_SET_RAW, 8'd23, 8'd23, 32'h8040_2010));
        pending.push_back(pixel_req(CMD_SET_RAW, 8'd2, 8'd0, 32'h0));
        pending.push_back(start_req(1'b1));
        repeat (12) pending.push_back(rand_req(CMD_NEXT));
        pending.push_back(start_req(1'b1));
        repeat (2) pending.push_back(rand_req(CMD_NEXT));
        pending.push_back(rand_req(CMD_CLEAR));
        pending.push_back(rand_req(CMD_NEXT));
        settle();

        set_missing(2'd1, 10'd0, 10'd0);
        queue_mixed(80);
        settle();

        set_missing(2'd2, 10'd3, 10'd5);
        queue_mixed(80);
        settle();

        set_missing(2'd3, 10'd575, 10'd574);
        queue_mixed(80);
        settle();

        idle_pct = 0;
        set_missing(2'd2, 10'd1023, 10'd1023);
        queue_mixed(150);
        settle();
        idle_pct = 32;

        set_missing(2'd2, 10'd4, 10'd4);
        queue_mixed(80);
        settle();

        set_missing(2'd0, 10'd2, 10'd7);
        queue_clear_burst();
        settle();

        repeat (4) begin
            set_missing(2'($urandom_range(3)),
                        MISS_W'($urandom_range(1) ? $urandom_range(20) : $urandom_range(1023)),
                        MISS_W'($urandom_range(1) ? $urandom_range(20) : $urandom_range(1023)));
            queue_mixed(100);
            settle();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && byte_expect.size() == 0) begin
            $display("PASS apa102_panel_frame_streamer");
        end else begin
            $display("FAIL apa102_panel_frame_streamer");
        end
        $finish;
    end

endmodule
